// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the occupancy grid block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sog_pkg.sv
// Package with the constants, codes, state type and sine table of the occupancy grid block.
package sog_pkg;

  localparam int GRID_CELLS = 32;
  localparam int SUB_SIDE   = 2 * GRID_CELLS;
  localparam int MAP_CM     = 4 * GRID_CELLS;
  localparam int DEPTH      = SUB_SIDE * SUB_SIDE;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int COORD_W = 11;
  localparam int ANG_W   = 11;
  localparam int PROD_W  = 26;
  localparam int Q_FRAC  = 14;
  localparam int Q_HALF  = 8192;

  localparam int EV_MIN      = -7;
  localparam int EV_MAX      = 7;
  localparam int DEG_FULL    = 360;
  localparam int DEG_QUARTER = 90;

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] CFG_POSE_X     = 2'd0;
  localparam logic [1:0] CFG_POSE_Y     = 2'd1;
  localparam logic [1:0] CFG_SENSOR_GAP = 2'd2;

  localparam logic [6:0] POSE_X_RESET     = 7'd40;
  localparam logic [6:0] POSE_Y_RESET     = 7'd20;
  localparam logic [4:0] SENSOR_GAP_RESET = 5'd5;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_NORM   = 11'b000_0000_0100,
    S_TRIG   = 11'b000_0000_1000,
    S_MUL    = 11'b000_0001_0000,
    S_ACC    = 11'b000_0010_0000,
    S_RND    = 11'b000_0100_0000,
    S_CHECK  = 11'b000_1000_0000,
    S_READ   = 11'b001_0000_0000,
    S_MODIFY = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  localparam logic [14:0] SIN_Q14 [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

endpackage

// File: sv/sonar_occupancy_grid_update.sv
// Top level of the sonar occupancy grid evidence counter with its grid memory and sequencer.
//
// After reset the block clears its 4096-entry grid memory (SUB_SIDE squared entries, one per
// cycle) and takes no word until the clear is done; configuration writes are taken at any time.
// A polar update first folds an angle outside 0 to 359 back into range, then uses one shared
// multiply, add and round unit that forms x and then y, plus a read-modify-write of the grid
// memory; a point outside the map skips the memory. A set or read word does the memory access
// alone, or skips it when its position lies outside the map. A new word is taken in the cycle
// after the previous result is handed to the output register, which holds it until it is taken.
`include "assert_macros.svh"

module sonar_occupancy_grid_update import sog_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [9:0]  angle,
  input  logic [7:0]         distance,
  input  logic signed [3:0]  delta,
  input  logic signed [8:0]  pos_x,
  input  logic signed [8:0]  pos_y,
  input  logic signed [3:0]  write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [3:0]  cell_value,
  output logic               in_range,
  output logic [5:0]         cell_col,
  output logic [5:0]         cell_row
);

  localparam logic [ADDR_W-1:0]        LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic signed [COORD_W-1:0] MAP_LIM  = COORD_W'(MAP_CM);

  state_t state, state_next;

  logic [6:0] pose_x;
  logic [6:0] pose_y;
  logic [4:0] sensor_gap;

  logic [ADDR_W-1:0] clr_cnt;
  logic              sel;

  logic [1:0]                act;
  logic signed [ANG_W-1:0]   ang;
  logic [8:0]                rad;
  logic signed [3:0]         dlt;
  logic signed [3:0]         wv;
  logic signed [15:0]        sin_v;
  logic signed [15:0]        cos_v;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic [ADDR_W-1:0]         addr;
  logic signed [3:0]         rd_data;
  logic signed [3:0]         res_value;
  logic                      res_in_range;
  logic [5:0]                res_col;
  logic [5:0]                res_row;

  logic signed [3:0] grid [DEPTH];

  logic                      in_accept;
  logic                      out_load;
  logic [8:0]                deg;
  logic [1:0]                quad;
  logic [6:0]                rem;
  logic signed [15:0]        t_r;
  logic signed [15:0]        t_c;
  logic signed [15:0]        coef;
  logic signed [7:0]         base;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [COORD_W-1:0] coord;
  logic                      in_map;
  logic [COORD_W-2:0]        col_full;
  logic [COORD_W-2:0]        row_full;
  logic signed [4:0]         sum;
  logic signed [3:0]         new_val;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [3:0]         mem_wdata;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Quadrant split of the reduced angle and table lookups.
  always_comb begin
    deg = ang[8:0];
    priority if (deg >= 9'(3 * DEG_QUARTER)) begin
      quad = 2'd3;
      rem  = 7'(deg - 9'(3 * DEG_QUARTER));
    end else if (deg >= 9'(2 * DEG_QUARTER)) begin
      quad = 2'd2;
      rem  = 7'(deg - 9'(2 * DEG_QUARTER));
    end else if (deg >= 9'(DEG_QUARTER)) begin
      quad = 2'd1;
      rem  = 7'(deg - 9'(DEG_QUARTER));
    end else begin
      quad = 2'd0;
      rem  = 7'(deg);
    end
    t_r = $signed({1'b0, SIN_Q14[rem]});
    t_c = $signed({1'b0, SIN_Q14[7'(DEG_QUARTER) - rem]});
  end

  // Shared multiply, accumulate and round unit.
  always_comb begin
    coef  = sel ? sin_v : cos_v;
    base  = sel ? ($signed({1'b0, pose_y}) - $signed({3'b000, sensor_gap}))
                : $signed({1'b0, pose_x});
    rnd   = acc + (acc[PROD_W-1] ? $signed(PROD_W'(Q_HALF - 1)) : $signed(PROD_W'(Q_HALF)));
    coord = COORD_W'(rnd >>> Q_FRAC);
  end

  always_comb begin
    in_map   = !cx[COORD_W-1] && !cy[COORD_W-1] && (cx < MAP_LIM) && (cy < MAP_LIM);
    col_full = cx[COORD_W-1:1];
    row_full = cy[COORD_W-1:1];
  end

  always_comb begin
    sum = $signed({rd_data[3], rd_data}) + $signed({dlt[3], dlt});
    priority if (act == ACT_UPDATE) begin
      new_val = (sum >= 5'(EV_MIN) && sum <= 5'(EV_MAX)) ? sum[3:0] : rd_data;
    end else if (act == ACT_SET) begin
      new_val = (wv < 4'(EV_MIN)) ? 4'(EV_MIN) : wv;
    end else begin
      new_val = rd_data;
    end
  end

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_MODIFY);
    mem_waddr = (state == S_CLEAR) ? clr_cnt : addr;
    mem_wdata = (state == S_CLEAR) ? 4'sd0 : new_val;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == LAST_ADDR) state_next = S_IDLE;
      S_IDLE:   if (in_accept) state_next = (action == ACT_UPDATE) ? S_NORM : S_CHECK;
      S_NORM:   if (!ang[ANG_W-1] && ang < ANG_W'(DEG_FULL)) state_next = S_TRIG;
      S_TRIG:   state_next = S_MUL;
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = S_RND;
      S_RND:    state_next = sel ? S_CHECK : S_MUL;
      S_CHECK:  state_next = in_map ? S_READ : S_DONE;
      S_READ:   state_next = S_MODIFY;
      S_MODIFY: state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      sel        <= 1'b0;
      out_valid  <= 1'b0;
      pose_x     <= POSE_X_RESET;
      pose_y     <= POSE_Y_RESET;
      sensor_gap <= SENSOR_GAP_RESET;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_TRIG) sel <= 1'b0;
      if (state == S_RND) sel <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_POSE_X:     pose_x     <= cfg_data;
          CFG_POSE_Y:     pose_y     <= cfg_data;
          CFG_SENSOR_GAP: sensor_gap <= cfg_data[4:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act <= action;
      ang <= ANG_W'(angle);
      rad <= 9'(distance) + 9'(sensor_gap);
      dlt <= delta;
      wv  <= write_value;
      cx  <= COORD_W'(pos_x);
      cy  <= COORD_W'(pos_y);
    end
    if (state == S_NORM) begin
      if (ang[ANG_W-1]) begin
        ang <= ang + ANG_W'(DEG_FULL);
      end else if (ang >= ANG_W'(DEG_FULL)) begin
        ang <= ang - ANG_W'(DEG_FULL);
      end
    end
    if (state == S_TRIG) begin
      unique case (quad)
        2'd0: begin sin_v <= t_r;  cos_v <= t_c;  end
        2'd1: begin sin_v <= t_c;  cos_v <= -t_r; end
        2'd2: begin sin_v <= -t_r; cos_v <= -t_c; end
        2'd3: begin sin_v <= -t_c; cos_v <= t_r;  end
        default: begin sin_v <= t_r; cos_v <= t_c; end
      endcase
    end
    if (state == S_MUL) prod <= PROD_W'($signed({1'b0, rad}) * coef);
    if (state == S_ACC) acc <= (PROD_W'(base) <<< Q_FRAC) + prod;
    if (state == S_RND) begin
      if (sel) cy <= coord;
      else cx <= coord;
    end
    if (state == S_CHECK) begin
      addr         <= ADDR_W'(row_full * SUB_SIDE + col_full);
      res_value    <= 4'sd0;
      res_in_range <= in_map;
      res_col      <= in_map ? 6'(col_full) : 6'd0;
      res_row      <= in_map ? 6'(row_full) : 6'd0;
    end
    if (state == S_MODIFY) res_value <= new_val;
    if (out_load) begin
      cell_value <= res_value;
      in_range   <= res_in_range;
      cell_col   <= res_col;
      cell_row   <= res_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_waddr] <= mem_wdata;
    rd_data <= grid[addr];
  end

  `ASSERT_CLK(a_accept_leaves_idle, clk, rst, in_accept |=> state != S_IDLE, "word accepted but sequencer stayed idle")
  `ASSERT_CLK(a_outside_zero, clk, rst, (out_valid && !in_range) |-> (cell_value == 4'sd0 && cell_col == 6'd0 && cell_row == 6'd0), "outside result word is not all zero")
  `ASSERT_CLK(a_value_in_span, clk, rst, (out_valid && in_range) |-> (cell_value != 4'sb1000), "cell value left the evidence span")
  `ASSERT_CLK_ALWAYS(a_reset_clears, clk, $past(rst) |-> state == S_CLEAR, "reset did not start the clearing pass")

endmodule
